// ===== hdl/rgbc_pkg.sv =====
// Shared types and constants for the 3x3 RGB convolution block.
package rgbc_pkg;
  localparam int unsigned PIX_BITS = 24;
  localparam int unsigned SUM_BITS = 21;
  localparam logic [7:0]  PIX_MAX  = 8'd255;

  localparam logic [2:0] REG_KTOP = 3'd0;
  localparam logic [2:0] REG_KMID = 3'd1;
  localparam logic [2:0] REG_KBOT = 3'd2;
  localparam logic [2:0] REG_DIV  = 3'd3;
  localparam logic [2:0] REG_WID  = 3'd4;
  localparam logic [2:0] REG_HGT  = 3'd5;

  // Job from the front part to the back part.
  typedef struct packed {
    logic                filt;  // run the kernel on the window
    logic [8:0][PIX_BITS-1:0] win;
    logic                done;
    logic                last;
  } job_t;
endpackage

// ===== hdl/rgbc_front.sv =====
// Front part: line stores, window, counters; emits jobs.
module rgbc_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [23:0]          pix_i,
  input  logic [15:0]          width_i,
  input  logic [15:0]          height_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output rgbc_pkg::job_t       job_o
);
  import rgbc_pkg::*;
  localparam int unsigned XW = $clog2(MAX_WIDTH);

  localparam logic [1:0] ST_IN = 2'd0;
  localparam logic [1:0] ST_RD = 2'd1;
  localparam logic [1:0] ST_J1 = 2'd2;
  localparam logic [1:0] ST_J2 = 2'd3;

  logic [PIX_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIX_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_BITS-1:0] old_rd_q, new_rd_q;

  logic [1:0] st_q, st_d;
  logic [8:0][PIX_BITS-1:0] win_q, win_d;
  logic [XW:0] col_q, col_d, drn_q, drn_d;
  logic [15:0] row_q, row_d;
  logic func_q;
  logic [PIX_BITS-1:0] pix_q;
  logic [XW-1:0] x_q;
  logic [XW:0] w_eff;
  logic [15:0] h_eff;
  logic acc, full;
  logic have1, have2;
  job_t j1_d, j1_q, j2_d, j2_q;
  logic [XW:0] xsel;

  always_comb begin
    w_eff = (width_i == '0) ? (XW+1)'(1) :
            (width_i > 16'(MAX_WIDTH)) ? (XW+1)'(MAX_WIDTH) : width_i[XW:0];
    h_eff = (height_i == '0) ? 16'd1 : height_i;
  end

  assign full = row_q >= h_eff;
  assign in_ready_o = (st_q == ST_IN);
  assign acc = in_valid_i && in_ready_o;
  assign xsel = func_i ? drn_q : col_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      x_q      <= (xsel >= (XW+1)'(MAX_WIDTH)) ? XW'(MAX_WIDTH-1) : xsel[XW-1:0];
      old_rd_q <= older_mem[(xsel >= (XW+1)'(MAX_WIDTH)) ? XW'(MAX_WIDTH-1) : xsel[XW-1:0]];
      new_rd_q <= newer_mem[(xsel >= (XW+1)'(MAX_WIDTH)) ? XW'(MAX_WIDTH-1) : xsel[XW-1:0]];
      pix_q    <= pix_i;
      func_q   <= func_i;
    end
    if (st_q == ST_RD && !func_q && !full) begin
      older_mem[x_q] <= new_rd_q;
      newer_mem[x_q] <= pix_q;
    end
    j1_q <= j1_d;
    j2_q <= j2_d;
  end

  always_comb begin
    st_d = st_q; win_d = win_q; col_d = col_q; row_d = row_q; drn_d = drn_q;
    j1_d = j1_q; j2_d = j2_q;
    have1 = 1'b0; have2 = 1'b0;
    unique case (st_q)
      ST_IN: if (acc) st_d = ST_RD;
      ST_RD: begin
        st_d = ST_IN;
        if (!func_q) begin
          if (!full) begin
            for (int r = 0; r < 3; r++) begin
              win_d[r*3]   = win_q[r*3+1];
              win_d[r*3+1] = win_q[r*3+2];
            end
            win_d[2] = old_rd_q;
            win_d[5] = new_rd_q;
            win_d[8] = pix_q;
            have1 = (row_q != 0) && (x_q != 0);
            have2 = ((XW+1)'(x_q) + 1'b1 >= w_eff) && (row_q != 0);
            j1_d.filt = (x_q >= XW'(2)) && ((XW+1)'(x_q) < w_eff) && (row_q >= 16'd2);
            j1_d.win  = win_d;
            j1_d.done = 1'b0;
            j1_d.last = !have2;
            j2_d.filt = 1'b0;
            j2_d.win  = '0;
            j2_d.win[4] = win_d[5];
            j2_d.done = 1'b0;
            j2_d.last = 1'b1;
            if ((XW+1)'(x_q) + 1'b1 >= w_eff) begin
              col_d = '0;
              row_d = row_q + 16'd1;
            end else col_d = (XW+1)'(x_q) + 1'b1;
          end
        end else if (full) begin
          have1 = 1'b1;
          j1_d.filt = 1'b0;
          j1_d.win = '0;
          j1_d.win[4] = new_rd_q;
          j1_d.done = ((XW+1)'(x_q) + 1'b1 >= w_eff);
          j1_d.last = 1'b1;
          if (j1_d.done) begin
            col_d = '0; row_d = '0; drn_d = '0;
          end else drn_d = (XW+1)'(x_q) + 1'b1;
        end
        if (have1) st_d = ST_J1;
        else if (have2) begin
          st_d = ST_J2;
        end
      end
      ST_J1: if (job_ready_i) st_d = j1_q.last ? ST_IN : ST_J2;
      ST_J2: if (job_ready_i) st_d = ST_IN;
      default: st_d = ST_IN;
    endcase
  end

  assign job_valid_o = (st_q == ST_J1) || (st_q == ST_J2);
  assign job_o = (st_q == ST_J2) ? j2_q : j1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IN; win_q <= '0; col_q <= '0; row_q <= '0; drn_q <= '0;
    end else begin
      st_q <= st_d; win_q <= win_d; col_q <= col_d; row_q <= row_d; drn_q <= drn_d;
    end
  end
endmodule

// ===== hdl/rgbc_back.sv =====
// Back part: kernel MAC, serial divide, clamp, output register.
module rgbc_back #(
  parameter int unsigned COEF_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  rgbc_pkg::job_t job_i,
  input  logic [71:0]    kern_i,
  input  logic [11:0]    div_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [25:0]    out_o
);
  import rgbc_pkg::*;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_CLP  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] st_q, st_d;
  job_t job_q;
  logic [3:0] tap_q;
  logic [1:0] ch_q;
  logic [4:0] bit_q;
  logic signed [SUM_BITS-1:0] sum_q;
  logic [SUM_BITS-1:0] quo_q, rem_q, mag;
  logic [11:0] dmag;
  logic neg;
  logic [23:0] res_q;
  logic [25:0] out_q;
  logic signed [COEF_BITS-1:0] cf;
  logic signed [8:0] px;
  logic signed [SUM_BITS-1:0] prod;
  logic signed [11:0] dv;
  logic [SUM_BITS:0] trial;
  logic signed [SUM_BITS:0] q_s;
  logic [7:0] clp;

  always_comb begin
    cf = COEF_BITS'(kern_i[tap_q*8 +: 8]);
    px = $signed({1'b0, job_q.win[tap_q][ch_q*8 +: 8]});
    prod = SUM_BITS'(px * cf);
    dv = (div_i == '0) ? 12'sd1 : $signed(div_i);
    // -2048 has a magnitude of 2048, so the magnitude keeps all 12 bits
    dmag = dv[11] ? 12'(-dv) : {1'b0, dv[10:0]};
    neg = sum_q[SUM_BITS-1] ^ dv[11];
    mag = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
    trial = {rem_q, quo_q[SUM_BITS-1]} - (SUM_BITS+1)'(dmag);
    q_s = neg ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    clp = (q_s < 0) ? 8'd0 : (q_s > $signed({14'd0, PIX_MAX})) ? PIX_MAX : q_s[7:0];
  end

  assign job_ready_o = (st_q == ST_IDLE);
  assign out_valid_o = (st_q == ST_OUT);
  assign out_o = out_q;

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: if (job_valid_i) begin
        job_q <= job_i; tap_q <= '0; ch_q <= '0; sum_q <= '0;
      end
      ST_MAC: begin
        sum_q <= sum_q + prod;
        tap_q <= tap_q + 4'd1;
        if (tap_q == 4'd8) begin
          quo_q <= '0; rem_q <= '0; bit_q <= '0;
        end
      end
      ST_DIV: begin
        if (bit_q == 5'd0) quo_q <= mag;
        else begin
          if (!trial[SUM_BITS]) begin
            rem_q <= trial[SUM_BITS-1:0];
            quo_q <= {quo_q[SUM_BITS-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[SUM_BITS-2:0], quo_q[SUM_BITS-1]};
            quo_q <= {quo_q[SUM_BITS-2:0], 1'b0};
          end
        end
        bit_q <= bit_q + 5'd1;
      end
      ST_CLP: begin
        res_q[ch_q*8 +: 8] <= clp;
        ch_q <= ch_q + 2'd1; tap_q <= '0; sum_q <= '0;
      end
      ST_OUT: ;
      default: ;
    endcase
    // border jobs go straight from idle, so take them from the job input
    if (st_d == ST_OUT && st_q != ST_OUT) begin
      if (st_q == ST_IDLE) out_q <= {job_i.last, job_i.done, job_i.win[4]};
      else out_q <= {job_q.last, job_q.done, clp, res_q[15:0]};
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (job_valid_i) st_d = job_i.filt ? ST_MAC : ST_OUT;
      ST_MAC:  if (tap_q == 4'd8) st_d = ST_DIV;
      ST_DIV:  if (bit_q == 5'(SUM_BITS)) st_d = ST_CLP;
      ST_CLP:  st_d = (ch_q == 2'd2) ? ST_OUT : ST_MAC;
      ST_OUT:  if (out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end
endmodule

// ===== hdl/rgb_convolution_3x3_clamped.sv =====
// Top level of the streaming 3x3 RGB convolution with clamp.
//  channel  dir  data                             flags                   handshake
//  s_axis   in   tdata: red, green, blue          tuser: func             tvalid/tready
//  m_axis   out  tdata: red, green, blue          tuser: done, tlast: end tvalid/tready
//  cfg      in   index (3), data (24)             -                       valid/ready
// A pixel passes through the front as a line-store read, then a window shift,
// then one handover per job; the back takes a filtered pixel through idle,
// then per channel 9 MAC taps, a load and 21 restoring divide steps and a
// clamp, then an output state; a border pixel goes from idle to output.
// Reset clears counters, window and control; line stores are not cleared.
// Either side may stall; the front holds its two job registers until the back
// takes them and accepts no pixel in the meantime.
module rgb_convolution_3x3_clamped #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned COEF_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
  output logic        m_axis_tuser,   // image_done
  output logic        m_axis_tlast,   // run_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import rgbc_pkg::*;
  logic [71:0] kern_q;
  logic [11:0] div_q;
  logic [15:0] wid_q, hgt_q;
  logic job_valid, job_ready;
  job_t job;
  logic [25:0] res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q <= {24'd0, 24'd256, 24'd0};
      div_q <= 12'd1; wid_q <= 16'd1024; hgt_q <= 16'd1024;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KTOP: kern_q[23:0]  <= cfg_data_i;
        REG_KMID: kern_q[47:24] <= cfg_data_i;
        REG_KBOT: kern_q[71:48] <= cfg_data_i;
        REG_DIV:  div_q <= cfg_data_i[11:0];
        REG_WID:  wid_q <= {5'd0, cfg_data_i[10:0]};
        REG_HGT:  hgt_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rgbc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .func_i(s_axis_tuser), .pix_i(s_axis_tdata),
    .width_i(wid_q), .height_i(hgt_q),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  rgbc_back #(.COEF_BITS(COEF_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .kern_i(kern_q), .div_i(div_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tdata = res[23:0];
  assign m_axis_tuser = res[24];
  assign m_axis_tlast = res[25];
endmodule
